@@ sv/round_robin_queue_expedite_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the round-robin queue with expedite
// Immediate-implication and next-cycle-implication checks on the top level
// clock and reset. They compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_QUEUE_EXPEDITE_TOP_DEFINES_SVH
`define ROUND_ROBIN_QUEUE_EXPEDITE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define RRQE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RRQE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RRQE_ASSERT_IMP(lbl, ante, cons, msg)
`define RRQE_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ sv/rrqe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrqe_pkg
// Types and codes shared by the queue segments and the top level.
// ----------------------------------------------------------------------------
package rrqe_pkg;

    localparam int unsigned SEG_CELLS = 32;

    localparam logic [1:0] CMD_SERVE    = 2'd0;
    localparam logic [1:0] CMD_EXPEDITE = 2'd1;
    localparam logic [1:0] CMD_RESTART  = 2'd2;

    localparam logic [2:0] ST_SERVED    = 3'd0;
    localparam logic [2:0] ST_EXPEDITED = 3'd1;
    localparam logic [2:0] ST_RESTARTED = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef enum logic [1:0] {
        MODE_SERVE,
        MODE_MOVE,
        MODE_SEARCH,
        MODE_RESTART
    } t_mode;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] client_id;
    } t_req;

    typedef struct packed {
        logic [31:0] served_id;
        logic [2:0]  status;
    } t_rsp;

    // Operation broadcast to every segment for the duration of a pass
    typedef struct packed {
        t_mode       mode;
        logic [31:0] id;
    } t_bcast;

    // Wavefront handed from one segment to the next
    typedef struct packed {
        logic        go;
        logic        found;
        logic        last_v;
        logic [31:0] last_d;
        logic [31:0] front_d;
    } t_link;

endpackage

@@ sv/rrqe_seg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrqe_seg
// One segment of the list: SEG_CELLS entries with valid bits. Updates its
// entries when the wavefront arrives and passes the wavefront on.
// ----------------------------------------------------------------------------
module rrqe_seg #(
    parameter int BASE = 0,
    parameter int CW   = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rrqe_pkg::t_bcast     i_bcast,
    input  logic [CW-1:0]        i_n,
    input  rrqe_pkg::t_link      i_link,
    output rrqe_pkg::t_link      o_link,
    input  logic [31:0]          i_next_d,
    input  logic                 i_next_v,
    output logic [31:0]          o_first_d,
    output logic                 o_first_v
);
    import rrqe_pkg::*;

    localparam bit IS_FRONT = (BASE == 0);

    logic [31:0]          r_d [SEG_CELLS];
    logic [SEG_CELLS-1:0] r_v;
    logic [31:0]          n_d [SEG_CELLS];
    logic [SEG_CELLS-1:0] n_v;
    logic [SEG_CELLS-1:0] w_match;
    logic [SEG_CELLS-1:0] w_before;
    logic [31:0]          w_front;
    t_link                r_link;

    assign w_front   = IS_FRONT ? r_d[0] : i_link.front_d;
    assign o_first_d = r_d[0];
    assign o_first_v = r_v[0];
    assign o_link    = r_link;

    always_comb begin
        logic [SEG_CELLS-1:0] below;
        logic [31:0]          left_d;
        logic [31:0]          right_d;
        logic                 left_v;
        logic                 right_v;
        logic [31:0]          idx;
        for (int k = 0; k < SEG_CELLS; k++) begin
            w_match[k] = r_v[k] && (r_d[k] == i_bcast.id);
        end
        for (int k = 0; k < SEG_CELLS; k++) begin
            below       = (SEG_CELLS'(1) << k) - SEG_CELLS'(1);
            w_before[k] = i_link.found | (|(w_match & below));
            left_d      = (k == 0) ? i_link.last_d : r_d[(k == 0) ? 0 : k - 1];
            left_v      = (k == 0) ? i_link.last_v : r_v[(k == 0) ? 0 : k - 1];
            right_d     = (k == SEG_CELLS - 1) ? i_next_d
                                               : r_d[(k == SEG_CELLS - 1) ? k : k + 1];
            right_v     = (k == SEG_CELLS - 1) ? i_next_v
                                               : r_v[(k == SEG_CELLS - 1) ? k : k + 1];
            idx         = 32'(BASE) + 32'(k);
            n_d[k]      = r_d[k];
            n_v[k]      = r_v[k];
            case (i_bcast.mode)
                MODE_SERVE: begin
                    // rotate left; the last valid entry takes the old front
                    if (r_v[k]) begin
                        n_d[k] = right_v ? right_d : w_front;
                    end
                end
                MODE_MOVE: begin
                    // shift right up to and including the matching entry
                    if (!w_before[k]) begin
                        n_d[k] = left_d;
                        n_v[k] = left_v;
                    end
                end
                MODE_RESTART: begin
                    n_v[k] = (idx < 32'(i_n));
                    n_d[k] = n_v[k] ? idx + 32'd1 : 32'd0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v       <= '0;
            r_link.go <= 1'b0;
        end else begin
            r_link.go <= i_link.go;
            if (i_link.go) begin
                r_v <= n_v;
            end
        end
        if (i_link.go) begin
            for (int k = 0; k < SEG_CELLS; k++) begin
                r_d[k] <= n_d[k];
            end
            r_link.found   <= i_link.found | (|w_match);
            r_link.last_d  <= r_d[SEG_CELLS-1];
            r_link.last_v  <= r_v[SEG_CELLS-1];
            r_link.front_d <= w_front;
        end
    end

endmodule

@@ sv/round_robin_queue_expedite_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_queue_expedite_top
// Ordered list of client identifiers: serve rotates the front to the back,
// expedite moves or inserts an identifier at the front, restart reloads 1..N.
// ----------------------------------------------------------------------------
// channel   direction  handshake                  payload
// request   in         start, busy                i_req  (cmd, client_id)
// response  out        o_rsp_valid (strobe)       o_rsp  (served_id, status)
// config    in         i_cfg_valid, o_cfg_ready   i_cfg_data (initial_count)
//
// The list is a chain of NSEG = ceil(LIST_DEPTH / 32) segments; a command
// sends a wavefront down the chain, one segment per cycle. A serve on an
// empty list answers without raising busy; other commands take one pass.
// An expedite on a full list runs a search pass first, then a move pass if
// the identifier is present; else it is dropped with full status. busy
// drops with the response strobe; reset empties the list.
// ----------------------------------------------------------------------------
`include "round_robin_queue_expedite_top_defines.svh"

module round_robin_queue_expedite_top #(
    parameter int LIST_DEPTH = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  rrqe_pkg::t_req i_req,
    output logic           o_rsp_valid,
    output rrqe_pkg::t_rsp o_rsp,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [10:0]    i_cfg_data
);
    import rrqe_pkg::*;

    localparam int NSEG = (LIST_DEPTH + SEG_CELLS - 1) / SEG_CELLS;
    localparam int CW   = $clog2(LIST_DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    t_state        r_state;
    logic [10:0]   r_cfg;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_n;
    logic [CW-1:0] w_n_sat;
    t_mode         r_mode;
    logic [31:0]   r_id;
    logic          r_go;
    logic          r_rsp_valid;
    t_rsp          r_rsp;
    t_bcast        w_bcast;
    t_link         w_link    [NSEG+1];
    logic [31:0]   w_first_d [NSEG+1];
    logic          w_first_v [NSEG+1];
    logic [NSEG:0] w_go;
    logic          w_done;

    assign busy        = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;
    assign o_cfg_ready = 1'b1;

    assign w_n_sat = (32'(r_cfg) > 32'(LIST_DEPTH)) ? CW'(LIST_DEPTH) : CW'(r_cfg);

    assign w_bcast.mode = r_mode;
    assign w_bcast.id   = r_id;

    // Left of the front sits the expedited identifier, marked valid
    assign w_link[0].go      = r_go;
    assign w_link[0].found   = 1'b0;
    assign w_link[0].last_v  = 1'b1;
    assign w_link[0].last_d  = r_id;
    assign w_link[0].front_d = 32'd0;

    assign w_first_d[NSEG] = 32'd0;
    assign w_first_v[NSEG] = 1'b0;
    assign w_done          = w_link[NSEG].go;

    for (genvar s = 0; s < NSEG; s++) begin : g_seg
        rrqe_seg #(
            .BASE (s * SEG_CELLS),
            .CW   (CW)
        ) u_seg (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_bcast   (w_bcast),
            .i_n       (r_n),
            .i_link    (w_link[s]),
            .o_link    (w_link[s+1]),
            .i_next_d  (w_first_d[s+1]),
            .i_next_v  (w_first_v[s+1]),
            .o_first_d (w_first_d[s]),
            .o_first_v (w_first_v[s])
        );
    end

    for (genvar s = 0; s <= NSEG; s++) begin : g_go
        assign w_go[s] = w_link[s].go;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= '0;
            r_count     <= '0;
            r_go        <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_id <= i_req.client_id;
                        case (i_req.cmd)
                            CMD_EXPEDITE: begin
                                r_mode      <= (r_count == CW'(LIST_DEPTH)) ? MODE_SEARCH
                                                                            : MODE_MOVE;
                                r_go        <= 1'b1;
                                r_rsp_valid <= 1'b0;
                                r_state     <= S_WALK;
                            end
                            CMD_RESTART: begin
                                r_n         <= w_n_sat;
                                r_mode      <= MODE_RESTART;
                                r_go        <= 1'b1;
                                r_rsp_valid <= 1'b0;
                                r_state     <= S_WALK;
                            end
                            default: begin
                                if (r_count == '0) begin
                                    r_go            <= 1'b0;
                                    r_rsp_valid     <= 1'b1;
                                    r_rsp.served_id <= 32'd0;
                                    r_rsp.status    <= ST_EMPTY;
                                end else begin
                                    r_mode      <= MODE_SERVE;
                                    r_go        <= 1'b1;
                                    r_rsp_valid <= 1'b0;
                                    r_state     <= S_WALK;
                                end
                            end
                        endcase
                    end else begin
                        r_go        <= 1'b0;
                        r_rsp_valid <= 1'b0;
                    end
                end
                S_WALK: begin
                    if (!w_done) begin
                        r_go        <= 1'b0;
                        r_rsp_valid <= 1'b0;
                    end else begin
                        case (r_mode)
                            MODE_SERVE: begin
                                r_go            <= 1'b0;
                                r_rsp_valid     <= 1'b1;
                                r_state         <= S_IDLE;
                                r_rsp.served_id <= w_link[NSEG].front_d;
                                r_rsp.status    <= ST_SERVED;
                            end
                            MODE_RESTART: begin
                                r_go            <= 1'b0;
                                r_rsp_valid     <= 1'b1;
                                r_state         <= S_IDLE;
                                r_count         <= r_n;
                                r_rsp.served_id <= 32'd0;
                                r_rsp.status    <= ST_RESTARTED;
                            end
                            MODE_MOVE: begin
                                if (!w_link[NSEG].found) begin
                                    r_count <= r_count + CW'(1);
                                end
                                r_go            <= 1'b0;
                                r_rsp_valid     <= 1'b1;
                                r_state         <= S_IDLE;
                                r_rsp.served_id <= 32'd0;
                                r_rsp.status    <= ST_EXPEDITED;
                            end
                            MODE_SEARCH: begin
                                // full list: move if present, else drop the request
                                if (w_link[NSEG].found) begin
                                    r_go        <= 1'b1;
                                    r_rsp_valid <= 1'b0;
                                    r_mode      <= MODE_MOVE;
                                end else begin
                                    r_go            <= 1'b0;
                                    r_rsp_valid     <= 1'b1;
                                    r_state         <= S_IDLE;
                                    r_rsp.served_id <= 32'd0;
                                    r_rsp.status    <= ST_FULL;
                                end
                            end
                            default: begin
                                r_go        <= 1'b0;
                                r_rsp_valid <= 1'b0;
                                r_state     <= S_IDLE;
                            end
                        endcase
                    end
                end
                default: begin
                    r_go        <= 1'b0;
                    r_rsp_valid <= 1'b0;
                    r_state     <= S_IDLE;
                end
            endcase
        end
    end

    `RRQE_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CW'(LIST_DEPTH), "count beyond depth")
    `RRQE_ASSERT_IMP(a_one_wave, 1'b1, $onehot0(w_go), "more than one wavefront in chain")
    `RRQE_ASSERT_IMP(a_rsp_idle, o_rsp_valid, r_state == S_IDLE, "response while busy")
    `RRQE_ASSERT_IMP(a_full_only, o_rsp_valid && (o_rsp.status == ST_FULL),
        r_count == CW'(LIST_DEPTH), "full status on a list that is not full")
    `RRQE_ASSERT_NXT(a_empty_serve,
        start && !busy && (i_req.cmd == CMD_SERVE) && (r_count == '0),
        o_rsp_valid && (o_rsp.status == ST_EMPTY), "empty serve not answered")

endmodule
